// File: sv/assert_macros.svh
//==============================================================================
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cbo_pkg.sv
//==============================================================================
// cbo_pkg
// Shared types and constants for the byte-offset decoder.
//==============================================================================
package cbo_pkg;

    localparam int LIMIT_W            = 25;
    localparam int PIXEL_W            = 32;
    localparam int COUNT_W            = 32;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 25'd16777216;
    localparam logic [7:0]         BYTE_ESCAPE  = 8'h80;
    localparam logic [15:0]        WORD_ESCAPE  = 16'h8000;
    localparam logic [31:0]        DWORD_ESCAPE = 32'h8000_0000;

    // Width of the delta currently being gathered
    typedef enum logic [1:0] {
        PHASE_BYTE  = 2'd0,
        PHASE_WORD  = 2'd1,
        PHASE_DWORD = 2'd2,
        PHASE_QWORD = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic               pixel_valid;
        logic               frame_end;
        logic [COUNT_W-1:0] rejected_count;
        logic               truncated;
    } result_t;

endpackage

// File: sv/cbo_input_reg.sv
//==============================================================================
// cbo_input_reg
// Input pipeline register; takes a new transaction whenever it empties.
//==============================================================================
module cbo_input_reg
    import cbo_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic [7:0] s_in_byte,
    input  logic     s_in_last,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // Refill in the same cycle the held transaction moves on
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data <= s_in_byte;
            item_reg.last <= s_in_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/cbo_decode_core.sv
//==============================================================================
// cbo_decode_core
// Escape decode, running sum and pixel accounting for one byte per cycle.
//==============================================================================
module cbo_decode_core
    import cbo_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  in_item_t           item,
    input  logic [LIMIT_W-1:0] output_limit,
    output logic               res_present,
    output result_t            res
);

    localparam int SHIFT_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    phase_t               phase_reg, phase_next, phase_upd;
    logic [2:0]           idx_reg, idx_next, idx_upd, idx_inc;
    logic [SHIFT_W-1:0]   shift_reg, shift_next, shift_upd, shift_in, gathered;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_upd;
    logic [LIMIT_W-1:0]   count_reg, count_next, count_upd;
    logic [COUNT_W-1:0]   reject_reg, reject_next, reject_upd;
    logic [63:0]          delta64;
    logic                 done;
    logic                 pix_ok;
    logic [PIXEL_W-1:0]   pix;

    assign shift_in = SHIFT_W'({56'd0, item.data} << {idx_reg, 3'b000});
    assign gathered = shift_reg | shift_in;
    assign idx_inc  = idx_reg + 3'd1;

    always_comb begin
        phase_upd  = phase_reg;
        idx_upd    = idx_reg;
        shift_upd  = shift_reg;
        acc_upd    = acc_reg;
        count_upd  = count_reg;
        reject_upd = reject_reg;
        delta64    = '0;
        done       = 1'b0;
        pix_ok     = 1'b0;

        unique case (phase_reg)
            PHASE_BYTE: begin
                if (item.data != BYTE_ESCAPE) begin
                    delta64 = {{56{item.data[7]}}, item.data};
                    done    = 1'b1;
                end else begin
                    phase_upd = PHASE_WORD;
                    idx_upd   = '0;
                    shift_upd = '0;
                end
            end
            PHASE_WORD: begin
                shift_upd = gathered;
                idx_upd   = idx_inc;
                if (idx_inc == 3'd2) begin
                    if (gathered[15:0] != WORD_ESCAPE) begin
                        delta64 = {{48{gathered[15]}}, gathered[15:0]};
                        done    = 1'b1;
                    end else begin
                        phase_upd = PHASE_DWORD;
                        idx_upd   = '0;
                        shift_upd = '0;
                    end
                end
            end
            PHASE_DWORD: begin
                shift_upd = gathered;
                idx_upd   = idx_inc;
                if (idx_inc == 3'd4) begin
                    if (gathered[31:0] != DWORD_ESCAPE) begin
                        delta64 = {{32{gathered[31]}}, gathered[31:0]};
                        done    = 1'b1;
                    end else begin
                        phase_upd = PHASE_QWORD;
                        idx_upd   = '0;
                        shift_upd = '0;
                    end
                end
            end
            PHASE_QWORD: begin
                // Bytes past max(VALUE_BITS,32) bits drop off the gather
                shift_upd = gathered;
                idx_upd   = idx_inc;
                if (idx_inc == 3'd0) begin
                    delta64 = 64'(gathered);
                    done    = 1'b1;
                end
            end
        endcase

        if (done) begin
            phase_upd = PHASE_BYTE;
            idx_upd   = '0;
            shift_upd = '0;
            acc_upd   = acc_reg + delta64[VALUE_BITS-1:0];
            if (count_reg < output_limit) begin
                count_upd = count_reg + LIMIT_W'(1);
                pix_ok    = 1'b1;
            end else if (reject_reg != '1) begin
                reject_upd = reject_reg + COUNT_W'(1);
            end
        end
    end

    // Final byte of a frame: clear everything for the next one
    always_comb begin
        if (item.last) begin
            phase_next  = PHASE_BYTE;
            idx_next    = '0;
            shift_next  = '0;
            acc_next    = '0;
            count_next  = '0;
            reject_next = '0;
        end else begin
            phase_next  = phase_upd;
            idx_next    = idx_upd;
            shift_next  = shift_upd;
            acc_next    = acc_upd;
            count_next  = count_upd;
            reject_next = reject_upd;
        end
    end

    generate
        if (VALUE_BITS >= PIXEL_W) begin : g_pix_trunc
            assign pix = acc_upd[PIXEL_W-1:0];
        end else begin : g_pix_sext
            assign pix = {{(PIXEL_W-VALUE_BITS){acc_upd[VALUE_BITS-1]}}, acc_upd};
        end
    endgenerate

    assign res_present        = pix_ok || item.last;
    assign res.pixel_value    = pix;
    assign res.pixel_valid    = pix_ok;
    assign res.frame_end      = item.last;
    assign res.rejected_count = reject_upd;
    assign res.truncated      = item.last && (phase_upd != PHASE_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_BYTE;
            idx_reg    <= '0;
            shift_reg  <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            reject_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            acc_reg    <= acc_next;
            count_reg  <= count_next;
            reject_reg <= reject_next;
        end
    end

endmodule

// File: sv/cbo_output_reg.sv
//==============================================================================
// cbo_output_reg
// Result register holding one transaction for the downstream side.
//==============================================================================
module cbo_output_reg
    import cbo_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

// File: sv/cbf_byte_offset_decoder.sv
//==============================================================================
// cbf_byte_offset_decoder
// Byte-offset decompressor for detector images, one byte a cycle unless stalled.
//==============================================================================
// The block takes the compressed stream one byte per transaction and sustains
// one byte per clock while the result side is not stalled. Each byte is a
// signed delta; 0x80 escapes to a 16-bit little-endian delta, 0x8000 to 32
// bits and 0x80000000 to 64 bits (only the low VALUE_BITS bits of that one
// are kept). Every completed delta is added to a wrapping VALUE_BITS-wide
// running sum, and the sum goes out as a pixel while fewer than output_limit
// pixels have been sent this frame; past the limit, pixels are dropped and
// counted in rejected_count (saturating). The byte flagged last always yields
// a result with frame_end set, truncated telling whether the stream stopped
// inside an escape, after which the frame state clears (output_limit keeps
// its value). Bytes in the middle of an escape, or pixels past the limit,
// produce no result. From input accept to result valid a byte passes the
// input register, then combinational decode and running-sum add feeding the
// result register. That sum feedback loop sets the one-byte-per-clock rate.
// Write output_limit through cfg_* only while no transaction is in flight.
//==============================================================================
module cbf_byte_offset_decoder
    import cbo_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // compressed byte stream
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_in_last,
    // decoded pixel results
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [PIXEL_W-1:0] m_pixel_value,
    output logic               m_pixel_valid,
    output logic               m_frame_end,
    output logic [COUNT_W-1:0] m_rejected_count,
    output logic               m_truncated,
    // output_limit register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

`include "assert_macros.svh"

    logic               item_valid;
    in_item_t           item;
    logic               advance;
    logic               res_present;
    result_t            res;
    result_t            res_out;
    logic [LIMIT_W-1:0] output_limit_reg;

    // Configuration: always ready, hold the limit across frames
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            output_limit_reg <= cfg_data;
        end
    end

    // Advance the held byte whenever the result register is free or draining
    assign advance = item_valid && (!m_valid || m_ready);

    cbo_input_reg u_input_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cbo_decode_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_decode_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item         (item),
        .output_limit (output_limit_reg),
        .res_present  (res_present),
        .res          (res)
    );

    // Load a result only for bytes that complete an in-limit pixel or end the frame
    cbo_output_reg u_output_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_present),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_out (res_out)
    );

    assign m_pixel_value    = res_out.pixel_value;
    assign m_pixel_valid    = res_out.pixel_valid;
    assign m_frame_end      = res_out.frame_end;
    assign m_rejected_count = res_out.rejected_count;
    assign m_truncated      = res_out.truncated;

    // A truncation flag only ever rides on the frame-end result
    `ASSERT_IMPLIES(a_trunc_on_end, aclk, aresetn, m_valid && m_truncated, m_frame_end, "truncated without frame_end")
    // Mid-frame results exist only to carry a pixel
    `ASSERT_IMPLIES(a_mid_has_pixel, aclk, aresetn, m_valid && !m_frame_end, m_pixel_valid, "empty mid-frame result")
    // A held byte must not vanish while the result side is stalled
    `ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, item_valid && m_valid && !m_ready, item_valid, "byte lost under stall")

endmodule
